@@ rtl/fgn_pkg.sv @@
package fgn_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 24;
    localparam int FREQ_W    = 24;
    localparam int PERS_W    = 18;
    localparam int AMP_W     = 32;
    localparam int SUM_W     = 41;
    localparam int LAT_W     = 8;

    // datapath widths
    localparam int PROD_W  = COORD_W + FREQ_W;
    localparam int AMPP_W  = AMP_W + PERS_W;
    localparam int OFS_W   = FRAC_BITS + 2;
    localparam int GRAD_W  = FRAC_BITS + 4;
    localparam int FADE_W  = FRAC_BITS + 1;
    localparam int INNER_W = FRAC_BITS + 6;
    localparam int TERM_W  = GRAD_W + AMP_W - FRAC_BITS;

    localparam logic [INNER_W-1:0] FADE_TEN = INNER_W'(10 << FRAC_BITS);
    localparam logic [OFS_W-1:0]   ONE_FX   = OFS_W'(1 << FRAC_BITS);

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_OCTAVE_COUNT,
        REG_BASE_FREQUENCY,
        REG_BASE_AMPLITUDE,
        REG_PERSISTENCE
    } cfg_reg_t;

    // per-octave payload carried down the chain
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [AMP_W-1:0]   amp;
        logic [SUM_W-1:0]   sum;
    } oct_bus_t;

    localparam logic [7:0] PERM_TABLE [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // permutation lookup, the 256-entry table wraps on the low 8 bits
    function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
        return PERM_TABLE[idx];
    endfunction

    // 12-gradient rule on signed offsets, low nibble of the hash selects
    function automatic logic signed [GRAD_W-1:0] grad_fx(
        input logic [7:0]              hash,
        input logic signed [OFS_W-1:0] gx,
        input logic signed [OFS_W-1:0] gy,
        input logic signed [OFS_W-1:0] gz
    );
        logic [3:0]               h;
        logic signed [OFS_W-1:0]  u;
        logic signed [OFS_W-1:0]  v;
        logic signed [GRAD_W-1:0] ue;
        logic signed [GRAD_W-1:0] ve;
        h  = hash[3:0];
        u  = (h < 4'd8) ? gx : gy;
        v  = (h < 4'd4) ? gy : ((h == 4'd12 || h == 4'd14) ? gx : gz);
        ue = GRAD_W'(u);
        ve = GRAD_W'(v);
        return (h[0] ? -ue : ue) + (h[1] ? -ve : ve);
    endfunction

    // a + floor(t * (b - a) / 2^F)
    function automatic logic signed [GRAD_W-1:0] lerp_fx(
        input logic [FADE_W-1:0]        t,
        input logic signed [GRAD_W-1:0] a,
        input logic signed [GRAD_W-1:0] b
    );
        logic signed [GRAD_W:0]              diff;
        logic signed [FADE_W+GRAD_W+1:0]     prod;
        diff = (GRAD_W+1)'(b) - (GRAD_W+1)'(a);
        prod = $signed({1'b0, t}) * diff;
        return a + GRAD_W'(prod >>> FRAC_BITS);
    endfunction

endpackage

@@ rtl/fgn_octave.sv @@
module fgn_octave #(
    parameter int OCT = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  fgn_pkg::oct_bus_t                in_bus,
    input  logic [fgn_pkg::FREQ_W-1:0]       base_frequency,
    input  logic [fgn_pkg::PERS_W-1:0]       persistence,
    input  logic [3:0]                       octave_count,
    output logic                             out_valid,
    output fgn_pkg::oct_bus_t                out_bus
);
    import fgn_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam logic [4:0] OCT_IDX = 5'(OCT);

    logic [8:0]  valid_reg;
    oct_bus_t    bus_reg [8];

    // stage 0 regs
    logic [PROD_W-1:0] s0_p_reg [3];
    logic [AMPP_W-1:0] s0_ampp_reg;
    // stage 1 regs
    logic [FB-1:0]     s1_t_reg [3];
    logic [2*FB-1:0]   s1_sq_reg [3];
    logic [7:0]        s1_a_reg;
    logic [7:0]        s1_b_reg;
    logic [7:0]        s1_z_reg;
    logic [AMP_W-1:0]  ampn_reg [7];
    // stage 2 regs
    logic [FB-1:0]     s2_t_reg [3];
    logic [2*FB-1:0]   s2_cub_reg [3];
    logic [INNER_W-1:0] s2_inner_reg [3];
    logic [7:0]        s2_aa_reg;
    logic [7:0]        s2_ab_reg;
    logic [7:0]        s2_ba_reg;
    logic [7:0]        s2_bb_reg;
    // stage 3 regs
    logic [FB+INNER_W-1:0]    s3_fp_reg [3];
    logic signed [GRAD_W-1:0] s3_g_reg [8];
    // stage 4..8 regs
    logic signed [GRAD_W-1:0] s4_x_reg [4];
    logic [FADE_W-1:0]        s4_fv_reg;
    logic [FADE_W-1:0]        s4_fw_reg;
    logic signed [GRAD_W-1:0] s5_y_reg [2];
    logic [FADE_W-1:0]        s5_fw_reg;
    logic signed [GRAD_W-1:0] s6_r_reg;
    logic [TERM_W-1:0]        s7_term_reg;
    oct_bus_t                 s8_bus_reg;

    // stage 1 comb
    logic [2*PROD_W-1:0] shifted [3];
    logic [COORD_W-1:0]  sc [3];
    logic [AMPP_W-FB-1:0] ampn_w;
    logic [AMP_W-1:0]    ampn_sat;
    // stage 2 comb
    logic [FB-1:0]       t2 [3];
    logic [INNER_W-1:0]  inner [3];
    // stage 3 comb
    logic [FB-1:0]           t3 [3];
    logic signed [OFS_W-1:0] f [3];
    logic signed [OFS_W-1:0] g [3];
    // stage 7 and 8 comb
    logic [GRAD_W-1:0]        r_abs;
    logic [GRAD_W+AMP_W-1:0]  term_p;
    logic [SUM_W-1:0]         sum_next;
    oct_bus_t                 bus_next;

    // valid shift register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[7:0], in_valid};
        end
    end

    // stage 1 scaled coordinate, amplitude saturation
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shifted[i] = (2*PROD_W)'(s0_p_reg[i]) << OCT;
            sc[i]      = shifted[i][FB +: COORD_W];
        end
        ampn_w   = s0_ampp_reg[FB +: (AMPP_W-FB)];
        ampn_sat = (|ampn_w[AMPP_W-FB-1:AMP_W]) ? '1 : ampn_w[AMP_W-1:0];
    end

    // stage 2 fade inner polynomial
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t2[i]    = s1_sq_reg[i][2*FB-1:FB];
            inner[i] = INNER_W'(t2[i]) * INNER_W'(6) + FADE_TEN
                     - INNER_W'(s1_t_reg[i]) * INNER_W'(15);
        end
    end

    // stage 3 offsets
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t3[i] = s2_cub_reg[i][2*FB-1:FB];
            f[i]  = $signed(OFS_W'(s2_t_reg[i]));
            g[i]  = $signed(OFS_W'(s2_t_reg[i]) - ONE_FX);
        end
    end

    // stage 7 absolute value and weighting, stage 8 accumulate
    always_comb
    begin
        r_abs    = s6_r_reg[GRAD_W-1] ? GRAD_W'(-s6_r_reg) : GRAD_W'(s6_r_reg);
        term_p   = (GRAD_W+AMP_W)'(r_abs) * (GRAD_W+AMP_W)'(bus_reg[6].amp);
        sum_next = bus_reg[7].sum;
        if (OCT_IDX < {1'b0, octave_count})
        begin
            sum_next = bus_reg[7].sum + SUM_W'(s7_term_reg);
        end
        bus_next     = bus_reg[7];
        bus_next.amp = ampn_reg[6];
        bus_next.sum = sum_next;
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 0 frequency scale and amplitude step
            s0_p_reg[0] <= PROD_W'(in_bus.x) * PROD_W'(base_frequency);
            s0_p_reg[1] <= PROD_W'(in_bus.y) * PROD_W'(base_frequency);
            s0_p_reg[2] <= PROD_W'(in_bus.z) * PROD_W'(base_frequency);
            s0_ampp_reg <= AMPP_W'(in_bus.amp) * AMPP_W'(persistence);
            bus_reg[0]  <= in_bus;

            // stage 1 square and first hash level
            for (int i = 0; i < 3; i++)
            begin
                s1_t_reg[i]  <= sc[i][FB-1:0];
                s1_sq_reg[i] <= (2*FB)'(sc[i][FB-1:0]) * (2*FB)'(sc[i][FB-1:0]);
            end
            s1_a_reg    <= perm_lookup(sc[0][FB +: LAT_W]) + sc[1][FB +: LAT_W];
            s1_b_reg    <= perm_lookup(sc[0][FB +: LAT_W] + 8'd1) + sc[1][FB +: LAT_W];
            s1_z_reg    <= sc[2][FB +: LAT_W];
            ampn_reg[0] <= ampn_sat;
            bus_reg[1]  <= bus_reg[0];

            // stage 2 cube and second hash level
            for (int i = 0; i < 3; i++)
            begin
                s2_t_reg[i]     <= s1_t_reg[i];
                s2_cub_reg[i]   <= (2*FB)'(t2[i]) * (2*FB)'(s1_t_reg[i]);
                s2_inner_reg[i] <= inner[i];
            end
            s2_aa_reg   <= perm_lookup(s1_a_reg) + s1_z_reg;
            s2_ab_reg   <= perm_lookup(s1_a_reg + 8'd1) + s1_z_reg;
            s2_ba_reg   <= perm_lookup(s1_b_reg) + s1_z_reg;
            s2_bb_reg   <= perm_lookup(s1_b_reg + 8'd1) + s1_z_reg;
            ampn_reg[1] <= ampn_reg[0];
            bus_reg[2]  <= bus_reg[1];

            // stage 3 fade product and corner gradients
            for (int i = 0; i < 3; i++)
            begin
                s3_fp_reg[i] <= (FB+INNER_W)'(t3[i]) * (FB+INNER_W)'(s2_inner_reg[i]);
            end
            s3_g_reg[0] <= grad_fx(perm_lookup(s2_aa_reg), f[0], f[1], f[2]);
            s3_g_reg[1] <= grad_fx(perm_lookup(s2_ba_reg), g[0], f[1], f[2]);
            s3_g_reg[2] <= grad_fx(perm_lookup(s2_ab_reg), f[0], g[1], f[2]);
            s3_g_reg[3] <= grad_fx(perm_lookup(s2_bb_reg), g[0], g[1], f[2]);
            s3_g_reg[4] <= grad_fx(perm_lookup(s2_aa_reg + 8'd1), f[0], f[1], g[2]);
            s3_g_reg[5] <= grad_fx(perm_lookup(s2_ba_reg + 8'd1), g[0], f[1], g[2]);
            s3_g_reg[6] <= grad_fx(perm_lookup(s2_ab_reg + 8'd1), f[0], g[1], g[2]);
            s3_g_reg[7] <= grad_fx(perm_lookup(s2_bb_reg + 8'd1), g[0], g[1], g[2]);
            ampn_reg[2] <= ampn_reg[1];
            bus_reg[3]  <= bus_reg[2];

            // stage 4 lerp along x
            s4_x_reg[0] <= lerp_fx(s3_fp_reg[0][FB +: FADE_W], s3_g_reg[0], s3_g_reg[1]);
            s4_x_reg[1] <= lerp_fx(s3_fp_reg[0][FB +: FADE_W], s3_g_reg[2], s3_g_reg[3]);
            s4_x_reg[2] <= lerp_fx(s3_fp_reg[0][FB +: FADE_W], s3_g_reg[4], s3_g_reg[5]);
            s4_x_reg[3] <= lerp_fx(s3_fp_reg[0][FB +: FADE_W], s3_g_reg[6], s3_g_reg[7]);
            s4_fv_reg   <= s3_fp_reg[1][FB +: FADE_W];
            s4_fw_reg   <= s3_fp_reg[2][FB +: FADE_W];
            ampn_reg[3] <= ampn_reg[2];
            bus_reg[4]  <= bus_reg[3];

            // stage 5 lerp along y
            s5_y_reg[0] <= lerp_fx(s4_fv_reg, s4_x_reg[0], s4_x_reg[1]);
            s5_y_reg[1] <= lerp_fx(s4_fv_reg, s4_x_reg[2], s4_x_reg[3]);
            s5_fw_reg   <= s4_fw_reg;
            ampn_reg[4] <= ampn_reg[3];
            bus_reg[5]  <= bus_reg[4];

            // stage 6 lerp along z
            s6_r_reg    <= lerp_fx(s5_fw_reg, s5_y_reg[0], s5_y_reg[1]);
            ampn_reg[5] <= ampn_reg[4];
            bus_reg[6]  <= bus_reg[5];

            // stage 7 weighted term
            s7_term_reg <= term_p[FB +: TERM_W];
            ampn_reg[6] <= ampn_reg[5];
            bus_reg[7]  <= bus_reg[6];

            // stage 8 running sum and next amplitude
            s8_bus_reg  <= bus_next;
        end
    end

    assign out_valid = valid_reg[8];
    assign out_bus   = s8_bus_reg;

endmodule

@@ rtl/fractal_gradient_noise_3d.sv @@
// channel | direction | handshake            | payload
// --------+-----------+----------------------+----------------------------------
// in      | input     | in_valid / in_stall   | x_coord, y_coord, z_coord
// out     | output    | out_valid / out_stall | noise_value, saturated
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one point per cycle while no held result stalls the pipeline; each point
// passes the chain of nine-stage octave pipelines and the output register.
// rst_n clears all valid bits and loads the default register values.
// a held result freezes the whole pipeline; in_stall follows that freeze.
module fractal_gradient_noise_3d #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fgn_pkg::COORD_W-1:0]    x_coord,
    input  logic [fgn_pkg::COORD_W-1:0]    y_coord,
    input  logic [fgn_pkg::COORD_W-1:0]    z_coord,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [31:0]                    noise_value,
    output logic                           saturated,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [23:0]                    cfg_data
);
    import fgn_pkg::*;

    logic [3:0]        octave_count_reg;
    logic [FREQ_W-1:0] base_frequency_reg;
    logic [FREQ_W-1:0] base_amplitude_reg;
    logic [PERS_W-1:0] persistence_reg;

    logic        en;
    logic        out_valid_reg;
    logic [31:0] noise_value_reg;
    logic        saturated_reg;

    logic     chain_valid [MAX_OCTAVES+1];
    oct_bus_t chain_bus   [MAX_OCTAVES+1];

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg   <= 4'd2;
            base_frequency_reg <= FREQ_W'(1 << FRAC_BITS);
            base_amplitude_reg <= FREQ_W'(1 << FRAC_BITS);
            persistence_reg    <= PERS_W'(1 << FRAC_BITS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OCTAVE_COUNT:   octave_count_reg   <= cfg_data[3:0];
                REG_BASE_FREQUENCY: base_frequency_reg <= cfg_data;
                REG_BASE_AMPLITUDE: base_amplitude_reg <= cfg_data;
                REG_PERSISTENCE:    persistence_reg    <= cfg_data[PERS_W-1:0];
                default:            octave_count_reg   <= octave_count_reg;
            endcase
        end
    end

    // pipeline advances unless a result is held
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // head of the octave chain
    assign chain_valid[0] = in_valid;
    assign chain_bus[0]   = {x_coord, y_coord, z_coord, AMP_W'(base_amplitude_reg),
                             SUM_W'(0)};

    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_oct
        fgn_octave #(
            .OCT (o)
        ) u_octave (
            .clk            (clk),
            .rst_n          (rst_n),
            .en             (en),
            .in_valid       (chain_valid[o]),
            .in_bus         (chain_bus[o]),
            .base_frequency (base_frequency_reg),
            .persistence    (persistence_reg),
            .octave_count   (octave_count_reg),
            .out_valid      (chain_valid[o+1]),
            .out_bus        (chain_bus[o+1])
        );
    end

    // output register with saturation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain_valid[MAX_OCTAVES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (|chain_bus[MAX_OCTAVES].sum[SUM_W-1:32])
            begin
                noise_value_reg <= '1;
                saturated_reg   <= 1'b1;
            end
            else
            begin
                noise_value_reg <= chain_bus[MAX_OCTAVES].sum[31:0];
                saturated_reg   <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_value_reg;
    assign saturated   = saturated_reg;

endmodule
